### hw/rtl/srp_pkg.sv
// Shared types and constants for the shelf rectangle packer.
// No dependencies; imported by the top level.
package srp_pkg;

	localparam int DIM_W  = 13;   // page sizes and shelf fields
	localparam int RECT_W = 12;   // requested sides and positions
	localparam int GAP_W  = 4;
	localparam int PAGE_W = 16;
	localparam int AREA_W = 32;
	localparam int STAT_W = 2;
	localparam int IDX_W  = 2;

	localparam logic [STAT_W-1:0] STATUS_PLACED    = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_ZERO_SIZE = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_TOO_LARGE = 2'd2;
	localparam logic [STAT_W-1:0] STATUS_CLEARED   = 2'd3;

	localparam logic [IDX_W-1:0] REG_PAGE_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_PAGE_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_GAP         = 2'd2;

	localparam logic [DIM_W-1:0] PAGE_WIDTH_RST  = 13'd1024;
	localparam logic [DIM_W-1:0] PAGE_HEIGHT_RST = 13'd1024;
	localparam logic [GAP_W-1:0] GAP_RST         = 4'd1;

	localparam logic KIND_PLACE = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	// one shelf as kept in the shelf memory
	typedef struct packed {
		logic [DIM_W-1:0] top;
		logic [DIM_W-1:0] tall;
		logic [DIM_W-1:0] cursor;
	} shelf_t;

	localparam int SHELF_BITS = 3 * DIM_W;

endpackage

### hw/rtl/srp_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module srp_ram #(
	parameter int WIDTH  = 39,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/shelf_rectangle_packer.sv
// Shelf rectangle packer: first-fit shelf placement into atlas pages.
// Per beat: a clear or a zero size goes straight to the result; a place scans the shelves in
// order, opens a new shelf on a miss, else a fresh page and one more try; output stalls hold the result.
// One shelf is read and compared per cycle from the shelf RAM; one beat at a time.
// Reset (arst_n low, async): no shelves, page 0, area 0, registers at defaults.
// Shelf RAM contents are not cleared; only entries below the shelf count are read.
module shelf_rectangle_packer
	import srp_pkg::*;
#(
	parameter int MAX_SHELVES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	// input beats
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [23:0]       s_tdata,    // rect_width[11:0], rect_height[23:12]
	input  logic [0:0]        s_tuser,    // kind[0]
	// result beats
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [71:0]       m_tdata,    // place_x[11:0], place_y[23:12],
	                                      // page_number[39:24], used_total[71:40]
	output logic [1:0]        m_tuser,    // status[1:0]
	// register writes
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DIM_W-1:0]  cfg_data
);

	localparam int AW = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
	localparam int CW = $clog2(MAX_SHELVES + 1);

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_NEW   = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0] state_q;

	// configuration
	logic [DIM_W-1:0] pwid_q, phgt_q;
	logic [GAP_W-1:0] gap_q;

	// packer state
	logic [CW-1:0]     count_q;
	logic [PAGE_W-1:0] page_q;
	logic [AREA_W-1:0] area_q;

	// current beat
	logic              kind_q;
	logic [RECT_W-1:0] w_q, h_q;
	logic [DIM_W-1:0]  pw_q, ph_q;          // padded sides
	logic [23:0]       prod_q;              // clamped area
	logic              add_q, retry_q;

	// scan pipeline
	logic [CW-1:0] issue_q;
	logic [AW-1:0] chk_q;
	logic          pend_q;
	logic [DIM_W:0] last_q;                 // top + tall of the last shelf checked

	// result holding
	logic [STAT_W-1:0] res_status_q;
	logic [RECT_W-1:0] res_x_q, res_y_q;

	// output register
	logic              m_tvalid_q;
	logic [STAT_W-1:0] o_status_q;
	logic [RECT_W-1:0] o_x_q, o_y_q;
	logic [PAGE_W-1:0] o_page_q;
	logic [AREA_W-1:0] o_area_q;

	// ---- clamp of the requested sides ----
	logic [GAP_W:0]    two_gap;
	logic [DIM_W-1:0]  lim_w, lim_h;
	logic [RECT_W-1:0] gw, gh;

	always_comb begin
		two_gap = {gap_q, 1'b0};
		lim_w = (pwid_q > DIM_W'(two_gap)) ? pwid_q - DIM_W'(two_gap) : '0;
		lim_h = (phgt_q > DIM_W'(two_gap)) ? phgt_q - DIM_W'(two_gap) : '0;
		gw = ({1'b0, w_q} < lim_w) ? w_q : lim_w[RECT_W-1:0];
		gh = ({1'b0, h_q} < lim_h) ? h_q : lim_h[RECT_W-1:0];
	end

	// ---- shelf RAM ----
	shelf_t         rd_shelf, wr_shelf;
	logic           ram_we, ram_re;
	logic [AW-1:0]  ram_waddr;
	logic [SHELF_BITS-1:0] ram_rdata;

	assign rd_shelf  = ram_rdata;
	assign ram_re    = (state_q == ST_SCAN) && (issue_q < count_q);

	srp_ram #(
		.WIDTH (SHELF_BITS),
		.DEPTH (MAX_SHELVES),
		.ADDR_W(AW)
	) u_shelves (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(wr_shelf),
		.re   (ram_re),
		.raddr(issue_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	// ---- shared fit check: scan compares a shelf, new-shelf compares the page bottom ----
	logic [DIM_W:0]   cur_end;
	logic             shelf_fit;
	logic [DIM_W+1:0] next_y, new_end;
	logic             new_fit;

	always_comb begin
		cur_end   = {1'b0, rd_shelf.cursor} + {1'b0, pw_q};
		shelf_fit = (cur_end <= {1'b0, pwid_q}) && (ph_q <= rd_shelf.tall);
		next_y    = (count_q == '0) ? '0 :
		            {1'b0, last_q} + (DIM_W+2)'(gap_q);
		new_end   = next_y + {2'b0, ph_q};
		new_fit   = (count_q < CW'(MAX_SHELVES)) &&
		            ((DIM_W+3)'(new_end) <= (DIM_W+3)'(phgt_q));
	end

	// RAM write: cursor bump on a hit, fresh shelf on open
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = chk_q;
		wr_shelf  = rd_shelf;
		if (state_q == ST_SCAN && pend_q && shelf_fit) begin
			ram_we          = 1'b1;
			wr_shelf.cursor = cur_end[DIM_W-1:0];
		end else if (state_q == ST_NEW && new_fit) begin
			ram_we          = 1'b1;
			ram_waddr       = count_q[AW-1:0];
			wr_shelf.top    = next_y[DIM_W-1:0];
			wr_shelf.tall   = ph_q;
			wr_shelf.cursor = pw_q;
		end
	end

	// saturating area total
	logic [AREA_W:0]   area_sum;
	logic [AREA_W-1:0] area_next;
	logic              out_free;

	always_comb begin
		area_sum  = {1'b0, area_q} + (AREA_W+1)'(prod_q);
		area_next = area_sum[AREA_W] ? '1 : area_sum[AREA_W-1:0];
		out_free  = !m_tvalid_q || m_tready;
	end

	// ---- configuration ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwid_q <= PAGE_WIDTH_RST;
			phgt_q <= PAGE_HEIGHT_RST;
			gap_q  <= GAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PAGE_WIDTH:  pwid_q <= cfg_data;
				REG_PAGE_HEIGHT: phgt_q <= cfg_data;
				REG_GAP:         gap_q  <= cfg_data[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			page_q       <= '0;
			area_q       <= '0;
			add_q        <= 1'b0;
			retry_q      <= 1'b0;
			pend_q       <= 1'b0;
			issue_q      <= '0;
			last_q       <= '0;
			res_status_q <= STATUS_PLACED;
			res_x_q      <= '0;
			res_y_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					add_q   <= 1'b0;
					retry_q <= 1'b0;
					issue_q <= '0;
					pend_q  <= 1'b0;
					res_x_q <= '0;
					res_y_q <= '0;
					if (kind_q == KIND_CLEAR) begin
						count_q      <= '0;
						page_q       <= '0;
						area_q       <= '0;
						res_status_q <= STATUS_CLEARED;
						state_q      <= ST_FIN;
					end else if (w_q == '0 || h_q == '0) begin
						res_status_q <= STATUS_ZERO_SIZE;
						state_q      <= ST_FIN;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					pend_q  <= ram_re;
					issue_q <= issue_q + CW'(ram_re);
					if (pend_q) begin
						last_q <= {1'b0, rd_shelf.top} + {1'b0, rd_shelf.tall};
					end
					if (pend_q && shelf_fit) begin
						res_x_q      <= rd_shelf.cursor[RECT_W-1:0];
						res_y_q      <= rd_shelf.top[RECT_W-1:0];
						res_status_q <= STATUS_PLACED;
						add_q        <= 1'b1;
						state_q      <= ST_FIN;
					end else if (!ram_re) begin
						state_q <= ST_NEW;
					end
				end
				ST_NEW: begin
					if (new_fit) begin
						count_q      <= count_q + 1'b1;
						res_x_q      <= '0;
						res_y_q      <= next_y[RECT_W-1:0];
						res_status_q <= STATUS_PLACED;
						add_q        <= 1'b1;
						state_q      <= ST_FIN;
					end else if (!retry_q) begin
						// fresh empty page, then one more try
						retry_q <= 1'b1;
						count_q <= '0;
						if (page_q != '1) begin
							page_q <= page_q + 1'b1;
						end
					end else begin
						res_x_q      <= '0;
						res_y_q      <= '0;
						res_status_q <= STATUS_TOO_LARGE;
						state_q      <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						if (add_q) begin
							area_q <= area_next;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result valid: set when a beat is loaded, dropped once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			kind_q <= s_tuser[0];
			w_q    <= s_tdata[11:0];
			h_q    <= s_tdata[23:12];
		end
		if (state_q == ST_SETUP) begin
			pw_q   <= DIM_W'(gw) + DIM_W'(gap_q);
			ph_q   <= DIM_W'(gh) + DIM_W'(gap_q);
			prod_q <= gw * gh;
		end
		if (state_q == ST_SCAN) begin
			chk_q <= issue_q[AW-1:0];
		end
		if (state_q == ST_FIN && out_free) begin
			o_status_q <= res_status_q;
			o_x_q      <= res_x_q;
			o_y_q      <= res_y_q;
			o_page_q   <= page_q;
			o_area_q   <= add_q ? area_next : area_q;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {o_area_q, o_page_q, o_y_q, o_x_q};
	assign m_tuser  = o_status_q;

	// ---- checks ----
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SHELVES))
		else $error("shelf count above limit");

	a_unplaced_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && o_status_q != STATUS_PLACED) |-> (o_x_q == '0 && o_y_q == '0))
		else $error("position set on a beat that was not placed");

	a_page_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(page_q < $past(page_q)) |-> ($past(state_q) == ST_SETUP && $past(kind_q) == KIND_CLEAR))
		else $error("page index fell without a clear");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && !out_free) |=> (state_q == ST_FIN))
		else $error("result left while output stalled");

endmodule
